>>> rtl/load_profile_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Load profile interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_PROFILE_INTERPOLATOR_MACROS_SVH
`define LOAD_PROFILE_INTERPOLATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lpi_pkg.sv
// ----------------------------------------------------------------------------
// Load profile interpolator package
// Constants, state encoding and calendar helpers for the interpolator.
// ----------------------------------------------------------------------------
package lpi_pkg;

	localparam int LPI_VALUE_WIDTH  = 32;
	localparam int LPI_DAY_SLOTS    = 96;
	localparam int LPI_LAST_SLOT    = 95;
	localparam int LPI_COLS         = 9;
	localparam int LPI_SLOT_SECONDS = 900;
	localparam int LPI_DAY_SECONDS  = 86400;
	localparam int LPI_DIGIT_BITS   = 8;
	localparam int LPI_REM_W        = $clog2(LPI_SLOT_SECONDS);
	localparam int LPI_ADDR_W       = $clog2(LPI_DAY_SLOTS * LPI_COLS);
	localparam int LPI_SEC_W        = 17;
	localparam int LPI_SLOT_DIV_W   = 24;
	localparam int LPI_SLOT_STEPS   = LPI_SLOT_DIV_W / LPI_DIGIT_BITS;

	// Calendar bounds of the seasons
	localparam logic [3:0] LPI_MONTH_FEB   = 4'd2;
	localparam logic [3:0] LPI_MONTH_MAR   = 4'd3;
	localparam logic [3:0] LPI_MONTH_MAY   = 4'd5;
	localparam logic [3:0] LPI_MONTH_JUN   = 4'd6;
	localparam logic [3:0] LPI_MONTH_AUG   = 4'd8;
	localparam logic [3:0] LPI_MONTH_SEP   = 4'd9;
	localparam logic [3:0] LPI_MONTH_NOV   = 4'd11;
	localparam logic [4:0] LPI_WINTER_END  = 5'd20;
	localparam logic [4:0] LPI_SUMMER_BEG  = 5'd15;
	localparam logic [4:0] LPI_SUMMER_END  = 5'd14;

	localparam logic [2:0] LPI_SUNDAY   = 3'd0;
	localparam logic [2:0] LPI_SATURDAY = 3'd6;

	localparam logic LPI_OP_WRITE = 1'b0;
	localparam logic LPI_OP_QUERY = 1'b1;

	localparam logic [1:0] LPI_SEASON_WINTER = 2'd0;
	localparam logic [1:0] LPI_SEASON_SUMMER = 2'd1;
	localparam logic [1:0] LPI_SEASON_TRANS  = 2'd2;

	localparam logic [1:0] LPI_DAY_SAT  = 2'd0;
	localparam logic [1:0] LPI_DAY_SUN  = 2'd1;
	localparam logic [1:0] LPI_DAY_WORK = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT,
		ST_RD_A,
		ST_RD_B,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} lpi_state_t;

	function automatic logic [1:0] lpi_season(input logic [3:0] month, input logic [4:0] day);
		logic [1:0] s;
		if (month >= LPI_MONTH_NOV || month <= LPI_MONTH_FEB ||
				(month == LPI_MONTH_MAR && day <= LPI_WINTER_END)) begin
			s = LPI_SEASON_WINTER;
		end else if ((month >= LPI_MONTH_JUN && month <= LPI_MONTH_AUG) ||
				(month == LPI_MONTH_MAY && day >= LPI_SUMMER_BEG) ||
				(month == LPI_MONTH_SEP && day <= LPI_SUMMER_END)) begin
			s = LPI_SEASON_SUMMER;
		end else begin
			s = LPI_SEASON_TRANS;
		end
		return s;
	endfunction

	function automatic logic [1:0] lpi_day_type(input logic [2:0] weekday);
		logic [1:0] d;
		if (weekday == LPI_SATURDAY) begin
			d = LPI_DAY_SAT;
		end else if (weekday == LPI_SUNDAY) begin
			d = LPI_DAY_SUN;
		end else begin
			d = LPI_DAY_WORK;
		end
		return d;
	endfunction

	// Flat table address: row * 9 + column
	function automatic logic [LPI_ADDR_W-1:0] lpi_addr(input logic [6:0] row,
			input logic [3:0] col);
		logic [LPI_ADDR_W-1:0] r;
		r = LPI_ADDR_W'(row);
		return (r << 3) + r + LPI_ADDR_W'(col);
	endfunction

endpackage

>>> rtl/load_profile_interpolator.sv
// ----------------------------------------------------------------------------
// Load profile interpolator
// Quarter-hour load profile table with linear interpolation inside a slot.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): op 0 writes entry_value into the table
//   at slot_index / column_index (out-of-range positions are dropped); op 1 is
//   a query built from month, day_of_month, weekday, seconds_of_day and
//   season_end_flags. A write produces no result, a query produces exactly one.
//   Output channel (out_valid / out_stall): load_value and column_error.
//   Timing: a write is taken in IDLE and leaves the sequencer there. A query
//   steps through SLOT, RD_A, RD_B, MUL, SUM, DIV and DONE, or from RD_A
//   straight to DONE when the shifted column is out of range; the next item
//   is taken once the sequencer is back in IDLE. The shared digit divider
//   runs at 8 quotient bits per cycle, once for the slot split of
//   seconds_of_day and once for the final division by 900; both reads use the single table port.
//   Reset clears the sequencer and the output valid; the table keeps whatever
//   it holds, and a query of an entry never written returns an arbitrary value.
//   While a result waits under out_stall the block may still take writes;
//   a finished query holds in its last state until the output register frees.
// ----------------------------------------------------------------------------
module load_profile_interpolator
	import lpi_pkg::*;
#(
	parameter int VALUE_WIDTH = LPI_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  logic [6:0]             slot_index,
	input  logic [3:0]             column_index,
	input  logic [VALUE_WIDTH-1:0] entry_value,
	input  logic [3:0]             month,
	input  logic [4:0]             day_of_month,
	input  logic [2:0]             weekday,
	input  logic [16:0]            seconds_of_day,
	input  logic [3:0]             season_end_flags,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] load_value,
	output logic                   column_error
);

	// Weighted sum fits VALUE_WIDTH + 10 bits; pad to whole divider digits
	localparam int PROD_W    = VALUE_WIDTH + LPI_REM_W;
	localparam int DIV_STEPS = (PROD_W + LPI_DIGIT_BITS - 1) / LPI_DIGIT_BITS;
	localparam int DIV_W     = DIV_STEPS * LPI_DIGIT_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int DEPTH     = LPI_DAY_SLOTS * LPI_COLS;

	lpi_state_t state_q, state_d;

	// Table memory, single port, registered read
	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic                   mem_we, mem_re;
	logic [LPI_ADDR_W-1:0]  mem_addr;

	// Query context
	logic [3:0]           col1_q;
	logic [3:0]           flags_q;
	logic [6:0]           row2_q;
	logic [3:0]           col2_q;
	logic [LPI_REM_W-1:0] rem_q;
	logic                 err_q;
	logic [VALUE_WIDTH-1:0] a_q;
	logic [PROD_W-1:0]    prod_a_q, prod_b_q;

	// Shared digit divider (divisor 900)
	logic [DIV_W-1:0]          div_num_q, div_quo_q;
	logic [LPI_REM_W-1:0]      div_rem_q, step_rem;
	logic [LPI_DIGIT_BITS-1:0] step_bits;
	logic [CNT_W-1:0]          div_cnt_q;
	logic                      div_load_slot, div_load_sum, div_step;

	logic                  in_accept, out_load;
	logic                  wr_in_range;
	logic [16:0]           secs_clamped;
	logic [6:0]            slot_row, prev_row;
	logic signed [5:0]     col2_calc;
	logic                  col2_bad;
	logic [LPI_REM_W-1:0]  weight_a;
	logic [PROD_W-1:0]     prod_sum;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                  out_error_q, out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign wr_in_range = (slot_index < 7'(LPI_DAY_SLOTS)) && (column_index < 4'(LPI_COLS));
	assign secs_clamped = (seconds_of_day >= 17'(LPI_DAY_SECONDS)) ?
		17'(LPI_DAY_SECONDS - 1) : seconds_of_day;

	// Slot from the first divider pass; previous slot wraps at midnight
	assign slot_row = div_quo_q[6:0];
	assign prev_row = (slot_row == 7'd0) ? 7'(LPI_LAST_SLOT) : slot_row - 7'd1;

	// Season-end shift of the second column applies in the last slot only
	always_comb begin
		col2_calc = $signed({2'b00, col1_q});
		if (slot_row == 7'(LPI_LAST_SLOT)) begin
			col2_calc = col2_calc + (flags_q[0] ? 6'sd6 : 6'sd0)
				+ (flags_q[1] ? 6'sd3 : 6'sd0)
				- (flags_q[2] ? 6'sd3 : 6'sd0)
				- (flags_q[3] ? 6'sd6 : 6'sd0);
		end
		col2_bad = (col2_calc < 6'sd0) || (col2_calc > 6'(LPI_COLS - 1));
	end

	assign weight_a = LPI_REM_W'(LPI_SLOT_SECONDS) - rem_q;
	assign prod_sum = prod_a_q + prod_b_q;

	// One quotient digit per cycle: eight restoring compare-subtract steps
	always_comb begin
		logic [LPI_REM_W:0] trial;
		step_rem  = div_rem_q;
		step_bits = '0;
		for (int i = 0; i < LPI_DIGIT_BITS; i++) begin
			trial = {step_rem, div_num_q[DIV_W-1-i]};
			if (trial >= (LPI_REM_W+1)'(LPI_SLOT_SECONDS)) begin
				step_rem = LPI_REM_W'(trial - (LPI_REM_W+1)'(LPI_SLOT_SECONDS));
				step_bits[LPI_DIGIT_BITS-1-i] = 1'b1;
			end else begin
				step_rem = trial[LPI_REM_W-1:0];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && op == LPI_OP_QUERY) begin
					state_d = ST_SLOT;
				end
			end
			ST_SLOT: begin
				if (div_cnt_q == CNT_W'(1)) begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				state_d = col2_bad ? ST_DONE : ST_RD_B;
			end
			ST_RD_B: state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == CNT_W'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_addr      = lpi_addr(slot_index, column_index);
		div_load_slot = 1'b0;
		div_load_sum  = 1'b0;
		div_step      = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mem_we        = in_accept && op == LPI_OP_WRITE && wr_in_range;
				div_load_slot = in_accept && op == LPI_OP_QUERY;
			end
			ST_SLOT: div_step = 1'b1;
			ST_RD_A: begin
				mem_re   = !col2_bad;
				mem_addr = lpi_addr(prev_row, col1_q);
			end
			ST_RD_B: begin
				mem_re   = 1'b1;
				mem_addr = lpi_addr(row2_q, col2_q);
			end
			ST_MUL:  ;
			ST_SUM:  div_load_sum = 1'b1;
			ST_DIV:  div_step = 1'b1;
			ST_DONE: out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (div_load_slot) begin
				div_cnt_q <= CNT_W'(LPI_SLOT_STEPS);
			end else if (div_load_sum) begin
				div_cnt_q <= CNT_W'(DIV_STEPS);
			end else if (div_step) begin
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
		end
	end

	// Table port: write wins, else registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= entry_value;
		end else if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		if (div_load_slot) begin
			// Left-align seconds so three digits finish the split
			div_num_q <= DIV_W'(secs_clamped) << (DIV_W - LPI_SLOT_DIV_W);
			div_quo_q <= '0;
			div_rem_q <= '0;
		end else if (div_load_sum) begin
			div_num_q <= DIV_W'(prod_sum);
			div_quo_q <= '0;
			div_rem_q <= '0;
		end else if (div_step) begin
			div_num_q <= div_num_q << LPI_DIGIT_BITS;
			div_quo_q <= {div_quo_q[DIV_W-LPI_DIGIT_BITS-1:0], step_bits};
			div_rem_q <= step_rem;
		end
	end

	// Query context and products
	always_ff @(posedge clk) begin
		if (div_load_slot) begin
			col1_q  <= ({2'b00, lpi_season(month, day_of_month)} << 1)
				+ {2'b00, lpi_season(month, day_of_month)}
				+ {2'b00, lpi_day_type(weekday)};
			flags_q <= season_end_flags;
		end
		if (state_q == ST_RD_A) begin
			row2_q <= slot_row;
			col2_q <= col2_calc[3:0];
			rem_q  <= div_rem_q;
			err_q  <= col2_bad;
		end
		if (state_q == ST_RD_B) begin
			a_q <= rd_data_q;
		end
		if (state_q == ST_MUL) begin
			prod_a_q <= PROD_W'(a_q) * PROD_W'(weight_a);
			prod_b_q <= PROD_W'(rd_data_q) * PROD_W'(rem_q);
		end
		if (out_load) begin
			out_value_q <= err_q ? '0 : div_quo_q[VALUE_WIDTH-1:0];
			out_error_q <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign load_value   = out_value_q;
	assign column_error = out_error_q;

endmodule

>>> rtl/lpi_checker.sv
// ----------------------------------------------------------------------------
// Load profile interpolator port checker
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`include "load_profile_interpolator_macros.svh"

module lpi_checker
	import lpi_pkg::*;
#(
	parameter int VALUE_WIDTH = LPI_VALUE_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   op,
	input logic [6:0]             slot_index,
	input logic [3:0]             column_index,
	input logic [VALUE_WIDTH-1:0] entry_value,
	input logic [3:0]             month,
	input logic [4:0]             day_of_month,
	input logic [2:0]             weekday,
	input logic [16:0]            seconds_of_day,
	input logic [3:0]             season_end_flags,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [VALUE_WIDTH-1:0] load_value,
	input logic                   column_error
);

	// Hold a stalled result
	`LPI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(load_value) && $stable(column_error), "stalled result changed")

	// Error results carry a zero value
	`LPI_ASSERT_SAME(a_err_zero, out_valid && column_error, load_value == '0, "column error with nonzero value")

	// A query keeps the block busy in the following cycle
	`LPI_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && op == LPI_OP_QUERY, in_stall, "query not followed by busy")

	// A write never produces a result transaction
	`LPI_ASSERT_NEXT(a_write_silent, in_valid && !in_stall && op == LPI_OP_WRITE && !out_valid, !out_valid, "write produced a result")

endmodule

bind load_profile_interpolator lpi_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_lpi_checker (.*);

>>> test/profile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile interpolator checker
// Watches both channels of the interpolator. It keeps a shadow copy of the
// profile table, predicts each query result as the query is accepted, and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module profile_checker
	import lpi_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       op,
	input  logic [6:0]                 slot_index,
	input  logic [3:0]                 column_index,
	input  logic [LPI_VALUE_WIDTH-1:0] entry_value,
	input  logic [3:0]                 month,
	input  logic [4:0]                 day_of_month,
	input  logic [2:0]                 weekday,
	input  logic [16:0]                seconds_of_day,
	input  logic [3:0]                 season_end_flags,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [LPI_VALUE_WIDTH-1:0] load_value,
	input  logic                       column_error,
	output int                         mismatches,
	output int                         readings_pending
);

	typedef struct packed {
		logic [LPI_VALUE_WIDTH-1:0] load_value;
		logic                       column_error;
	} reading_t;

	logic [LPI_VALUE_WIDTH-1:0] profile_copy [LPI_DAY_SLOTS][LPI_COLS];
	reading_t                   expected_readings [$];

	function automatic reading_t interpolate_reading(input logic [3:0] mon,
			input logic [4:0] day, input logic [2:0] wd, input logic [16:0] secs_in,
			input logic [3:0] flags);
		reading_t          r;
		int                season;
		int                day_kind;
		int                first_col;
		int                second_col;
		int                cur_row;
		int                prev_row;
		longint unsigned   secs;
		longint unsigned   rem;
		longint unsigned   prev_val;
		longint unsigned   cur_val;
		if (mon >= LPI_MONTH_NOV || mon <= LPI_MONTH_FEB ||
				(mon == LPI_MONTH_MAR && day <= LPI_WINTER_END)) begin
			season = LPI_SEASON_WINTER;
		end else if ((mon >= LPI_MONTH_JUN && mon <= LPI_MONTH_AUG) ||
				(mon == LPI_MONTH_MAY && day >= LPI_SUMMER_BEG) ||
				(mon == LPI_MONTH_SEP && day <= LPI_SUMMER_END)) begin
			season = LPI_SEASON_SUMMER;
		end else begin
			season = LPI_SEASON_TRANS;
		end
		if (wd == LPI_SATURDAY) begin
			day_kind = LPI_DAY_SAT;
		end else if (wd == LPI_SUNDAY) begin
			day_kind = LPI_DAY_SUN;
		end else begin
			day_kind = LPI_DAY_WORK;
		end
		first_col = season * 3 + day_kind;
		// clamp past-midnight seconds to the last second of the day
		secs = (secs_in >= LPI_DAY_SECONDS) ? LPI_DAY_SECONDS - 1 : secs_in;
		cur_row = int'(secs / LPI_SLOT_SECONDS);
		prev_row = (cur_row == 0) ? LPI_LAST_SLOT : cur_row - 1;
		rem = secs % LPI_SLOT_SECONDS;
		second_col = first_col;
		if (cur_row == LPI_LAST_SLOT) begin
			if (flags[0]) second_col += 6;
			if (flags[1]) second_col += 3;
			if (flags[2]) second_col -= 3;
			if (flags[3]) second_col -= 6;
		end
		if (second_col < 0 || second_col >= LPI_COLS) begin
			r.load_value = '0;
			r.column_error = 1'b1;
		end else begin
			prev_val = profile_copy[prev_row][first_col];
			cur_val = profile_copy[cur_row][second_col];
			r.load_value = LPI_VALUE_WIDTH'((prev_val * (LPI_SLOT_SECONDS - rem) +
				cur_val * rem) / LPI_SLOT_SECONDS);
			r.column_error = 1'b0;
		end
		return r;
	endfunction

	function automatic void note_fault(input string what, input reading_t want,
			input reading_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t checker: %s: expected value %h error %b, got value %h error %b",
				$time, what, want.load_value, want.column_error, got.load_value,
				got.column_error);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			expected_readings.delete();
			readings_pending <= 0;
		end else begin
			// results first: a result never belongs to a query accepted on this edge
			if (out_valid && !out_stall) begin
				got.load_value = load_value;
				got.column_error = column_error;
				if (expected_readings.size() == 0) begin
					note_fault("result with no query waiting", '0, got);
				end else begin
					want = expected_readings.pop_front();
					if (got.load_value !== want.load_value ||
							got.column_error !== want.column_error) begin
						note_fault("result mismatch", want, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (op == LPI_OP_WRITE) begin
					if (slot_index < LPI_DAY_SLOTS && column_index < LPI_COLS) begin
						profile_copy[slot_index][column_index] = entry_value;
					end
				end else begin
					expected_readings.push_back(interpolate_reading(month, day_of_month,
						weekday, seconds_of_day, season_end_flags));
				end
			end
			readings_pending <= expected_readings.size();
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load profile interpolator testbench
// Drives table writes and interpolation queries into the interpolator with
// bursty input traffic and a randomly stalling receiver. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import lpi_pkg::*;

	// transactions to send, directed ones included (ignored writes do not count)
	localparam int TARGET_ITEMS = 1300;
	// slack after the last result
	localparam int SETTLE_CYCLES = 40;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       op;
	logic [6:0]                 slot_index;
	logic [3:0]                 column_index;
	logic [LPI_VALUE_WIDTH-1:0] entry_value;
	logic [3:0]                 month;
	logic [4:0]                 day_of_month;
	logic [2:0]                 weekday;
	logic [16:0]                seconds_of_day;
	logic [3:0]                 season_end_flags;
	logic                       out_valid;
	logic                       out_stall;
	logic [LPI_VALUE_WIDTH-1:0] load_value;
	logic                       column_error;
	int                         mismatches;
	int                         readings_pending;

	// entries written so far: a query never reads an entry that was not written
	bit entry_written [LPI_DAY_SLOTS][LPI_COLS];
	int burst_left;
	int items_sent;

	load_profile_interpolator u_dut (.*);

	profile_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// End the run if traffic or results stop flowing.
	initial begin
		#8_000_000;
		$display("load_profile_interpolator verification failed");
		$finish;
	end

	// Receiver: stall in stretches of changing character, from never stalling
	// to stalling most cycles, so that results back up at every stage.
	initial begin
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 1) == 1);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Between transactions: keep valid high inside a burst, drop it for a
	// random gap at the end of one and pick the next burst length.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 9);
		end
	endtask

	// Present one transaction at the falling edge and hold it until a rising
	// edge finds the block not stalling.
	task automatic put_item(input logic item_op, input logic [6:0] slot,
			input logic [3:0] col, input logic [LPI_VALUE_WIDTH-1:0] value,
			input logic [3:0] mon, input logic [4:0] day, input logic [2:0] wd,
			input logic [16:0] secs, input logic [3:0] flags);
		@(negedge clk);
		in_valid <= 1'b1;
		op <= item_op;
		slot_index <= slot;
		column_index <= col;
		entry_value <= value;
		month <= mon;
		day_of_month <= day;
		weekday <= wd;
		seconds_of_day <= secs;
		season_end_flags <= flags;
		do @(posedge clk); while (in_stall);
		if (item_op == LPI_OP_QUERY) begin
			items_sent++;
		end else if (slot < LPI_DAY_SLOTS && col < LPI_COLS) begin
			entry_written[slot][col] = 1'b1;
			items_sent++;
		end
		pace_sender();
	endtask

	// Table values lean toward the extremes.
	function automatic logic [LPI_VALUE_WIDTH-1:0] fill_value();
		logic [LPI_VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			2: v = LPI_VALUE_WIDTH'($urandom_range(0, 255));
			default: v = LPI_VALUE_WIDTH'($urandom);
		endcase
		return v;
	endfunction

	// Write one entry; the query fields carry noise.
	task automatic write_entry(input logic [6:0] slot, input logic [3:0] col,
			input logic [LPI_VALUE_WIDTH-1:0] value);
		put_item(LPI_OP_WRITE, slot, col, value, 4'($urandom), 5'($urandom),
			3'($urandom), 17'($urandom), 4'($urandom));
	endtask

	// Work out which two entries a query reads; returns 0 when the shifted
	// column is out of range and nothing is read.
	function automatic bit query_reads(input logic [3:0] mon, input logic [4:0] day,
			input logic [2:0] wd, input logic [16:0] secs, input logic [3:0] flags,
			output int prev_row, output int first_col, output int cur_row,
			output int second_col);
		int season;
		int day_kind;
		int clamped;
		if (mon >= LPI_MONTH_NOV || mon <= LPI_MONTH_FEB ||
				(mon == LPI_MONTH_MAR && day <= LPI_WINTER_END)) begin
			season = LPI_SEASON_WINTER;
		end else if ((mon >= LPI_MONTH_JUN && mon <= LPI_MONTH_AUG) ||
				(mon == LPI_MONTH_MAY && day >= LPI_SUMMER_BEG) ||
				(mon == LPI_MONTH_SEP && day <= LPI_SUMMER_END)) begin
			season = LPI_SEASON_SUMMER;
		end else begin
			season = LPI_SEASON_TRANS;
		end
		day_kind = (wd == LPI_SATURDAY) ? LPI_DAY_SAT :
			(wd == LPI_SUNDAY) ? LPI_DAY_SUN : LPI_DAY_WORK;
		first_col = season * 3 + day_kind;
		clamped = (secs >= LPI_DAY_SECONDS) ? LPI_DAY_SECONDS - 1 : int'(secs);
		cur_row = clamped / LPI_SLOT_SECONDS;
		prev_row = (cur_row == 0) ? LPI_LAST_SLOT : cur_row - 1;
		second_col = first_col;
		if (cur_row == LPI_LAST_SLOT) begin
			second_col += (flags[0] ? 6 : 0) + (flags[1] ? 3 : 0) -
				(flags[2] ? 3 : 0) - (flags[3] ? 6 : 0);
		end
		return second_col >= 0 && second_col < LPI_COLS;
	endfunction

	// Issue a query, first writing any entry it reads that is still blank.
	task automatic ask_reading(input logic [3:0] mon, input logic [4:0] day,
			input logic [2:0] wd, input logic [16:0] secs, input logic [3:0] flags);
		int prev_row;
		int first_col;
		int cur_row;
		int second_col;
		if (query_reads(mon, day, wd, secs, flags, prev_row, first_col, cur_row,
				second_col)) begin
			if (!entry_written[prev_row][first_col]) begin
				write_entry(7'(prev_row), 4'(first_col), fill_value());
			end
			if (!entry_written[cur_row][second_col]) begin
				write_entry(7'(cur_row), 4'(second_col), fill_value());
			end
		end
		put_item(LPI_OP_QUERY, 7'($urandom), 4'($urandom), LPI_VALUE_WIDTH'($urandom),
			mon, day, wd, secs, flags);
	endtask

	// Random query, weighted toward season boundaries, the last slot, slot
	// edges and out-of-range dates and times.
	task automatic random_query();
		logic [3:0]  mon;
		logic [4:0]  day;
		logic [16:0] secs;
		mon = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(1, 12));
		case ($urandom_range(0, 5))
			0: day = 5'($urandom_range(0, 31));
			1: day = 5'(LPI_SUMMER_END + $urandom_range(0, 1));
			2: day = 5'(LPI_WINTER_END + $urandom_range(0, 1));
			default: day = 5'($urandom_range(1, 31));
		endcase
		case ($urandom_range(0, 9))
			0: secs = 17'($urandom_range(LPI_DAY_SECONDS, 17'h1FFFF));
			1, 2: secs = 17'($urandom_range(LPI_LAST_SLOT * LPI_SLOT_SECONDS,
				LPI_DAY_SECONDS - 1));
			3: secs = 17'($urandom_range(0, LPI_LAST_SLOT) * LPI_SLOT_SECONDS +
				($urandom_range(0, 1) ? LPI_SLOT_SECONDS - 1 : 0));
			default: secs = 17'($urandom_range(0, LPI_DAY_SECONDS - 1));
		endcase
		ask_reading(mon, day, 3'($urandom_range(0, 7)), secs, 4'($urandom_range(0, 15)));
	endtask

	// Random write: mostly valid positions, some the block must drop.
	task automatic random_write();
		case ($urandom_range(0, 19))
			0, 1: write_entry(7'($urandom_range(LPI_DAY_SLOTS, 127)), 4'($urandom),
				fill_value());
			2: write_entry(7'($urandom), 4'($urandom_range(LPI_COLS, 15)), fill_value());
			default: write_entry(7'($urandom_range(0, LPI_LAST_SLOT)),
				4'($urandom_range(0, LPI_COLS - 1)), fill_value());
		endcase
	endtask

	// Hold the input idle until every query has its result.
	task automatic drain_readings();
		@(negedge clk) in_valid <= 1'b0;
		wait (readings_pending == 0);
	endtask

	initial begin
		in_valid = 1'b0;
		op = LPI_OP_WRITE;
		slot_index = '0;
		column_index = '0;
		entry_value = '0;
		month = '0;
		day_of_month = '0;
		weekday = '0;
		seconds_of_day = '0;
		season_end_flags = '0;
		arst_n = 1'b0;
		burst_left = 0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Drop writes outside the table: slot past the day, column past 8.
		write_entry(7'd96, 4'd0, '1);
		write_entry(7'd127, 4'd8, '1);
		write_entry(7'd5, 4'd9, '1);
		write_entry(7'd5, 4'd15, '1);
		// Seed the wraparound pair with full scale and zero.
		write_entry(7'(LPI_LAST_SLOT), 4'd0, '1);
		write_entry(7'd0, 4'd0, '0);

		// Winter Saturday at midnight: slot 0 reads back into the last slot.
		ask_reading(4'd1, 5'd1, 3'd6, 17'd0, 4'd0);
		// Last winter day, Sunday, end of slot; flags must not act here.
		ask_reading(4'd3, 5'd20, 3'd0, 17'd899, 4'd15);
		// First transitional day, mid slot.
		ask_reading(4'd3, 5'd21, 3'd3, 17'd450, 4'd0);
		// Transitional and first summer day at either end of the same slot.
		ask_reading(4'd5, 5'd14, 3'd1, 17'd901, 4'd0);
		ask_reading(4'd5, 5'd15, 3'd6, 17'd1799, 4'd0);
		// Last second of the day, summer Sunday shifted up by three.
		ask_reading(4'd9, 5'd14, 3'd0, 17'd86399, 4'd2);
		// Shift past the last column: error.
		ask_reading(4'd9, 5'd15, 3'd5, 17'd85500, 4'd1);
		// Seconds past the day clamp into the last slot; shift below zero.
		ask_reading(4'd11, 5'd1, 3'd2, 17'd86400, 4'd4);
		// Month and day zero, weekday seven, seconds at the top; shifts cancel.
		ask_reading(4'd0, 5'd0, 3'd7, 17'h1FFFF, 4'd9);
		// Month fifteen counts as winter; all four flags cancel.
		ask_reading(4'd15, 5'd31, 3'd6, 17'd86399, 4'd15);
		// Summer Saturday shifted down by six: error.
		ask_reading(4'd7, 5'd4, 3'd6, 17'd86000, 4'd8);
		// Noon in December, flags set outside the last slot.
		ask_reading(4'd12, 5'd25, 3'd0, 17'd43200, 4'd15);

		// Let the pipeline empty completely once before the random traffic.
		drain_readings();

		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 1) == 0) begin
				random_query();
			end else begin
				random_write();
			end
			if ($urandom_range(0, 299) == 0) begin
				drain_readings();
			end
		end

		drain_readings();
		// Give a stray result time to show up after the last expected one.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && readings_pending == 0) begin
			$display("load_profile_interpolator verification clean");
		end else begin
			$display("load_profile_interpolator verification failed");
		end
		$finish;
	end

endmodule
